[src/serial_command_motor_decoder_unit_assert.svh]
// assertion macros for the serial command motor decoder
`ifndef SERIAL_COMMAND_MOTOR_DECODER_UNIT_ASSERT_SVH
`define SERIAL_COMMAND_MOTOR_DECODER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define SCMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
// antecedent implies consequent in the next cycle
`define SCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SCMD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SCMD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/scmd_pkg.sv]
// shared constants and types for the serial command motor decoder
`default_nettype none

package scmd_pkg;

    // frame and token characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // command characters
    localparam logic [7:0] CMD_DRIVE = 8'h44;
    localparam logic [7:0] CMD_PLANT = 8'h50;
    localparam logic [7:0] CMD_STOP  = 8'h53;

    localparam logic [7:0] SPEED_LIMIT_RST = 8'd245;
    localparam int         MAG_W           = 10;
    localparam logic [MAG_W-1:0] MAG_MAX   = 10'd1023;
    localparam int         RESULT_W        = 24;

    // acknowledge codes
    typedef enum logic [1:0] {
        ACK_DRIVE = 2'd0,
        ACK_PLANT = 2'd1,
        ACK_BRAKE = 2'd2
    } ack_t;

    // token parse phase
    typedef enum logic [1:0] {
        PH_GAP  = 2'd0,
        PH_LEAD = 2'd1,
        PH_NUM  = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    // whitespace in the atoi sense
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

[src/serial_command_motor_decoder_unit.sv]
// top level: framed ascii command decoder producing motor drive results
// Takes one received character per item on the slave stream and accepts an item in
// every cycle while no held result stalls it. Commands are framed by '<' and '>':
// 'D,left,right' drives both motors, 'S' brakes both, 'P' is acknowledged only; empty
// frames and unknown commands give no result. A result leaves through a registered
// master stream in the cycle after the item carrying '>' is accepted; s_axis_tready
// stays high while the output register is empty or being drained, so the sustained
// rate is one item per clock, limited only by the consumer taking results. Content
// beyond BUFFER_BYTES-1 characters is ignored, a zero byte ends the content, and parsed
// speeds saturate at 1023 before the clamp to the speed limit register (reset 245).
`default_nettype none

`include "serial_command_motor_decoder_unit_assert.svh"

module serial_command_motor_decoder_unit #(
    parameter int BUFFER_BYTES = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration: speed_limit
    input  wire logic                          cfg_wr_en,
    input  wire logic [7:0]                    cfg_wr_data,
    // slave stream: tdata = rx_byte[7:0]
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,
    // master stream: tdata = ack_code[1:0], motor_update[2], left_dir_a[3],
    // left_dir_b[4], left_duty[12:5], right_dir_a[13], right_dir_b[14],
    // right_duty[22:15], zero[23]
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [scmd_pkg::RESULT_W-1:0]      m_axis_tdata
);

    import scmd_pkg::*;

    localparam int              CNT_W   = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(BUFFER_BYTES - 1);

    // parse state
    logic             in_frame_reg,  in_frame_next;
    logic [CNT_W-1:0] count_reg,     count_next;
    logic             ended_reg,     ended_next;
    logic [1:0]       tok_num_reg,   tok_num_next;
    phase_t           phase_reg,     phase_next;
    logic             neg_reg,       neg_next;
    logic [MAG_W-1:0] mag_reg,       mag_next;
    logic [7:0]       cmd_reg,       cmd_next;
    logic             left_neg_reg,  left_neg_next;
    logic [MAG_W-1:0] left_mag_reg,  left_mag_next;
    logic             right_neg_reg, right_neg_next;
    logic [MAG_W-1:0] right_mag_reg, right_mag_next;
    logic [7:0]       limit_reg;

    // output register
    logic                m_valid_reg, m_valid_next;
    logic [RESULT_W-1:0] m_data_reg,  m_data_next;

    logic             in_fire;
    logic             close_tok;
    logic             res_fire;
    ack_t             ack;
    logic             motor_upd;
    phase_t           ph;
    logic [13:0]      mag_sum;
    logic [MAG_W-1:0] mag_sat;
    logic [7:0]       left_duty;
    logic [7:0]       right_duty;
    logic             left_a, left_b, right_a, right_b;

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // decimal accumulate with saturation
    assign mag_sum = 14'(mag_reg) * 14'd10 + 14'(4'(s_axis_tdata - CH_ZERO));
    assign mag_sat = (mag_sum > 14'(MAG_MAX)) ? MAG_MAX : mag_sum[MAG_W-1:0];

    // next parse state per received item
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        ended_next     = ended_reg;
        tok_num_next   = tok_num_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        cmd_next       = cmd_reg;
        left_neg_next  = left_neg_reg;
        left_mag_next  = left_mag_reg;
        right_neg_next = right_neg_reg;
        right_mag_next = right_mag_reg;
        close_tok      = 1'b0;
        res_fire       = 1'b0;
        ph             = phase_reg;

        if (in_fire)
        begin
            if (!in_frame_reg)
            begin
                if (s_axis_tdata == CH_LT)
                begin
                    in_frame_next  = 1'b1;
                    count_next     = '0;
                    ended_next     = 1'b0;
                    tok_num_next   = 2'd0;
                    phase_next     = PH_GAP;
                    neg_next       = 1'b0;
                    mag_next       = '0;
                    cmd_next       = CH_NUL;
                    left_neg_next  = 1'b0;
                    left_mag_next  = '0;
                    right_neg_next = 1'b0;
                    right_mag_next = '0;
                end
            end
            else if (s_axis_tdata != CH_GT)
            begin
                if (count_reg < CNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                    if (!ended_reg)
                    begin
                        if (s_axis_tdata == CH_NUL)
                        begin
                            ended_next = 1'b1;
                        end
                        else if (s_axis_tdata == CH_COMMA)
                        begin
                            close_tok = (phase_reg != PH_GAP);
                        end
                        else
                        begin
                            if (ph == PH_GAP)
                            begin
                                if (tok_num_reg == 2'd0)
                                begin
                                    cmd_next = s_axis_tdata;
                                end
                                ph         = PH_LEAD;
                                phase_next = PH_LEAD;
                            end
                            if (ph == PH_LEAD)
                            begin
                                if (is_space(s_axis_tdata))
                                begin
                                    phase_next = PH_LEAD;
                                end
                                else if (s_axis_tdata == CH_MINUS || s_axis_tdata == CH_PLUS)
                                begin
                                    neg_next   = (s_axis_tdata == CH_MINUS);
                                    phase_next = PH_NUM;
                                end
                                else
                                begin
                                    ph = PH_NUM;
                                end
                            end
                            if (ph == PH_NUM)
                            begin
                                if (s_axis_tdata >= CH_ZERO && s_axis_tdata <= CH_NINE)
                                begin
                                    mag_next   = mag_sat;
                                    phase_next = PH_NUM;
                                end
                                else
                                begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                    end
                end
            end
            else
            begin
                // closing marker: finish the open token and report
                in_frame_next = 1'b0;
                close_tok     = (phase_reg != PH_GAP);
                res_fire      = (cmd_reg == CMD_DRIVE) || (cmd_reg == CMD_PLANT)
                             || (cmd_reg == CMD_STOP);
            end
        end

        // token close stores the speed and resets the accumulator
        if (close_tok)
        begin
            if (tok_num_reg == 2'd1)
            begin
                left_neg_next = neg_reg;
                left_mag_next = mag_reg;
            end
            else if (tok_num_reg == 2'd2)
            begin
                right_neg_next = neg_reg;
                right_mag_next = mag_reg;
            end
            if (tok_num_reg != 2'd3)
            begin
                tok_num_next = tok_num_reg + 2'd1;
            end
            phase_next = PH_GAP;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
    end

    // clamp speeds and map to direction pins and duty
    always_comb
    begin
        left_duty  = (left_mag_next > 10'(limit_reg)) ? limit_reg : left_mag_next[7:0];
        right_duty = (right_mag_next > 10'(limit_reg)) ? limit_reg : right_mag_next[7:0];
        left_a     = left_neg_next && (left_duty != 8'd0);
        left_b     = !left_neg_next && (left_duty != 8'd0);
        right_a    = right_neg_next && (right_duty != 8'd0);
        right_b    = !right_neg_next && (right_duty != 8'd0);

        case (cmd_reg)
            CMD_DRIVE:
            begin
                ack       = ACK_DRIVE;
                motor_upd = 1'b1;
            end
            CMD_STOP:
            begin
                ack       = ACK_BRAKE;
                motor_upd = 1'b1;
                left_duty = 8'd0;  right_duty = 8'd0;
                left_a    = 1'b0;  left_b     = 1'b0;
                right_a   = 1'b0;  right_b    = 1'b0;
            end
            default:
            begin
                ack       = ACK_PLANT;
                motor_upd = 1'b0;
                left_duty = 8'd0;  right_duty = 8'd0;
                left_a    = 1'b0;  left_b     = 1'b0;
                right_a   = 1'b0;  right_b    = 1'b0;
            end
        endcase

        m_data_next  = {1'b0, right_duty, right_b, right_a, left_duty, left_b, left_a,
                        motor_upd, ack};
        m_valid_next = res_fire || (m_valid_reg && !m_axis_tready);
    end

    // state and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            ended_reg     <= 1'b0;
            tok_num_reg   <= 2'd0;
            phase_reg     <= PH_GAP;
            neg_reg       <= 1'b0;
            mag_reg       <= '0;
            cmd_reg       <= CH_NUL;
            left_neg_reg  <= 1'b0;
            left_mag_reg  <= '0;
            right_neg_reg <= 1'b0;
            right_mag_reg <= '0;
            limit_reg     <= SPEED_LIMIT_RST;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            ended_reg     <= ended_next;
            tok_num_reg   <= tok_num_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            mag_reg       <= mag_next;
            cmd_reg       <= cmd_next;
            left_neg_reg  <= left_neg_next;
            left_mag_reg  <= left_mag_next;
            right_neg_reg <= right_neg_next;
            right_mag_reg <= right_mag_next;
            m_valid_reg   <= m_valid_next;
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (res_fire)
        begin
            m_data_reg <= m_data_next;
        end
    end

    // checks on the decoder's own logic
    `SCMD_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_MAX)
    `SCMD_ASSERT_NEXT(a_frame_closes, clk, rst_n,
        in_fire && in_frame_reg && (s_axis_tdata == CH_GT), !in_frame_reg)
    `SCMD_ASSERT_NOW(a_plant_quiet, clk, rst_n,
        m_valid_reg && (m_data_reg[1:0] == ACK_PLANT), m_data_reg[22:2] == 21'd0)
    `SCMD_ASSERT_NOW(a_left_pins, clk, rst_n,
        m_valid_reg, !(m_data_reg[3] && m_data_reg[4])
        && ((m_data_reg[3] || m_data_reg[4]) == (m_data_reg[12:5] != 8'd0)))
    `SCMD_ASSERT_NOW(a_right_pins, clk, rst_n,
        m_valid_reg, !(m_data_reg[13] && m_data_reg[14])
        && ((m_data_reg[13] || m_data_reg[14]) == (m_data_reg[22:15] != 8'd0)))

endmodule

`default_nettype wire
